// ===== rtl/sync_length_frame_receiver_unit_defines.svh =====
// Assertion macros for the receiver's RTL, included by slfr_core.sv.
`ifndef SYNC_LENGTH_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define SYNC_LENGTH_FRAME_RECEIVER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLFR_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
	else $error("receiver assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SLFR_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
	else $error("receiver assertion failed");

`endif

// ===== rtl/slfr_pkg.sv =====
`default_nettype none
package slfr_pkg;

	localparam logic [1:0] ST_PAYLOAD = 2'd0;
	localparam logic [1:0] ST_ABORT   = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;

	localparam logic CFG_SYNC_VALUE    = 1'b0;
	localparam logic CFG_TIMEOUT_LIMIT = 1'b1;

	localparam logic [7:0] SYNC_VALUE_RESET    = 8'h98;
	localparam logic [7:0] TIMEOUT_LIMIT_RESET = 8'd5;
	localparam logic [1:0] SYNC_NEEDED         = 2'd3;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_IDLE = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  payload_byte;
		logic        last;
		logic [15:0] frame_length;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/slfr_if.sv =====
`default_nettype none
interface slfr_item_if import slfr_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] rx_byte;

	modport source (output valid, output kind, output rx_byte, input ready);
	modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface slfr_result_if import slfr_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  payload_byte;
	logic        last;
	logic [15:0] frame_length;

	modport source (output valid, output status, output payload_byte, output last,
		output frame_length, input ready);
	modport sink (input valid, input status, input payload_byte, input last,
		input frame_length, output ready);
endinterface
`default_nettype wire

// ===== rtl/slfr_in_stage.sv =====
`default_nettype none
module slfr_in_stage import slfr_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	slfr_item_if.sink   items,
	input  wire logic   advance,
	output item_t       item_s1,
	output logic        valid_s1
);

	assign items.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.valid && items.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1.kind    <= items.kind;
			item_s1.rx_byte <= items.rx_byte;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/slfr_core.sv =====
`default_nettype none
`include "sync_length_frame_receiver_unit_defines.svh"
module slfr_core import slfr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       step,
	input  wire item_t      item,
	output result_t         res,
	output logic            res_valid
);

	typedef enum logic [1:0] {PH_SYNC, PH_LEN_HI, PH_LEN_LO, PH_PAYLOAD} phase_t;

	phase_t      phase_q, phase_d;
	logic [1:0]  matches_q, matches_d;
	logic [7:0]  count_q, count_d;
	logic [15:0] length_q, length_d;
	logic [15:0] bytes_q, bytes_d;
	logic [7:0]  sync_value_q;
	logic [7:0]  timeout_limit_q;

	logic        is_byte;
	logic        do_tick;
	logic        clear;
	logic [15:0] full_len;
	logic [15:0] bytes_n;

	always_comb begin
		is_byte   = (item.kind == KIND_BYTE);
		phase_d   = phase_q;
		matches_d = matches_q;
		count_d   = count_q;
		length_d  = length_q;
		bytes_d   = bytes_q;
		do_tick   = 1'b0;
		clear     = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		full_len  = {length_q[15:8], item.rx_byte};
		bytes_n   = bytes_q + 16'd1;

		case (phase_q)
			PH_SYNC: begin
				do_tick = 1'b1;
				if (is_byte) begin
					if (item.rx_byte == sync_value_q) begin
						if (matches_q == SYNC_NEEDED - 2'd1) begin
							phase_d   = PH_LEN_HI;
							matches_d = 2'd0;
							count_d   = 8'd0;
							length_d  = 16'd0;
							do_tick   = 1'b0;
						end else begin
							matches_d = matches_q + 2'd1;
						end
					end else begin
						matches_d = 2'd0;
					end
				end
			end
			PH_LEN_HI: begin
				do_tick = 1'b1;
				if (is_byte) begin
					length_d = {item.rx_byte, 8'h00};
					phase_d  = PH_LEN_LO;
				end
			end
			PH_LEN_LO: begin
				if (is_byte) begin
					if (full_len == 16'd0) begin
						res_valid = 1'b1;
						res.status = ST_EMPTY;
						res.last   = 1'b1;
						clear      = 1'b1;
					end else begin
						phase_d  = PH_PAYLOAD;
						length_d = full_len;
						count_d  = 8'd0;
						bytes_d  = 16'd0;
					end
				end else begin
					do_tick = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				if (is_byte) begin
					res_valid          = 1'b1;
					res.status         = ST_PAYLOAD;
					res.payload_byte   = item.rx_byte;
					res.last           = (bytes_n >= length_q);
					res.frame_length   = length_q;
					bytes_d            = bytes_n;
					clear              = (bytes_n >= length_q);
				end else begin
					do_tick = 1'b1;
				end
			end
			default: begin
				clear = 1'b1;
			end
		endcase

		if (do_tick) begin
			if (count_q > timeout_limit_q) begin
				res_valid        = 1'b1;
				res.status       = ST_ABORT;
				res.payload_byte = 8'h00;
				res.last         = 1'b1;
				res.frame_length = length_d;
				clear            = 1'b1;
			end else if (count_q != 8'hFF) begin
				count_d = count_q + 8'd1;
			end
		end

		if (clear) begin
			phase_d   = PH_SYNC;
			matches_d = 2'd0;
			count_d   = 8'd0;
			length_d  = 16'd0;
			bytes_d   = 16'd0;
		end

		if (!step) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_SYNC;
			matches_q       <= 2'd0;
			count_q         <= 8'd0;
			length_q        <= 16'd0;
			bytes_q         <= 16'd0;
			sync_value_q    <= SYNC_VALUE_RESET;
			timeout_limit_q <= TIMEOUT_LIMIT_RESET;
		end else begin
			if (step) begin
				phase_q   <= phase_d;
				matches_q <= matches_d;
				count_q   <= count_d;
				length_q  <= length_d;
				bytes_q   <= bytes_d;
			end
			if (cfg_we && cfg_index == CFG_SYNC_VALUE) begin
				sync_value_q <= cfg_data;
			end
			if (cfg_we && cfg_index == CFG_TIMEOUT_LIMIT) begin
				timeout_limit_q <= cfg_data;
			end
		end
	end

	`SLFR_ASSERT_NOW(a_matches_below_needed, clk, arst_n, 1'b1, matches_q != SYNC_NEEDED)
	`SLFR_ASSERT_NOW(a_matches_only_hunting, clk, arst_n, phase_q != PH_SYNC, matches_q == 2'd0)
	`SLFR_ASSERT_NOW(a_payload_len_nonzero, clk, arst_n, phase_q == PH_PAYLOAD, length_q != 16'd0)
	`SLFR_ASSERT_NOW(a_payload_count_short, clk, arst_n, phase_q == PH_PAYLOAD, bytes_q < length_q)
	`SLFR_ASSERT_NEXT(a_result_clears_or_continues, clk, arst_n,
		step && res_valid && res.last, phase_q == PH_SYNC)

endmodule
`default_nettype wire

// ===== rtl/slfr_out_stage.sv =====
`default_nettype none
module slfr_out_stage import slfr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     load,
	input  wire result_t  res,
	output logic          free,
	slfr_result_if.source results
);

	logic    valid_q;
	result_t data_q;

	assign free                 = !valid_q || results.ready;
	assign results.valid        = valid_q;
	assign results.status       = data_q.status;
	assign results.payload_byte = data_q.payload_byte;
	assign results.last         = data_q.last;
	assign results.frame_length = data_q.frame_length;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= res;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sync_length_frame_receiver_unit.sv =====
// Deframer for a serial byte stream carrying sync-marked, length-prefixed frames.
// The items channel takes one received byte or one idle tick per request; the
// results channel returns payload bytes, timeout aborts and empty-frame notices.
// Configuration writes (sync byte at index 0, timeout limit at index 1) are made
// through cfg_we, cfg_index and cfg_data; the user must make them only while the
// block is idle, and the block itself does not enforce this.
// An accepted item waits in the input register until the output register is free;
// a result it causes is loaded into the output register as the item is processed.
// Throughput is one item per clock cycle while the results channel does not stall,
// set by the single state update loop of the frame state registers.
// Reset returns the block to sync hunting, clears the frame state, restores the
// register defaults and empties both the input and the output registers.
// When the results channel stalls, the pending result stays in the output
// register, one more item waits in the input register, and items.ready falls.
`default_nettype none
module sync_length_frame_receiver_unit import slfr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data,
	slfr_item_if.sink       items,
	slfr_result_if.source   results
);

	item_t   item_s1;
	logic    valid_s1;
	logic    out_free;
	logic    advance;
	result_t res;
	logic    res_valid;

	assign advance = valid_s1 && out_free;

	slfr_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.advance  (advance),
		.item_s1  (item_s1),
		.valid_s1 (valid_s1)
	);

	slfr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (advance),
		.item      (item_s1),
		.res       (res),
		.res_valid (res_valid)
	);

	slfr_out_stage u_out_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (res_valid),
		.res     (res),
		.free    (out_free),
		.results (results)
	);

endmodule
`default_nettype wire
